[rtl/dpm_pkg.sv]
// ----------------------------------------------------------------------------
// Dew point package
// Request and result types and fixed-point constants for the dew point block.
// ----------------------------------------------------------------------------
`default_nettype none

package dpm_pkg;

  // Request: temperature in 0.01 degC, relative humidity in 0.01 %
  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic        [13:0] humidity_centi;
  } sample_t;

  // Result: dew point in 0.01 degC and the low-humidity flag
  typedef struct packed {
    logic signed [14:0] dew_point_centi;
    logic               humidity_clamped;
  } result_t;

  // Fraction bits of the log mantissa
  localparam int MANT_BITS = 20;

  // ln(10000) in Q28
  localparam logic signed [35:0] LN10000_Q28 = 36'sd2472381918;

  // 17.62 * 2^28 scaled by 100, the base of the final divisor
  localparam logic signed [41:0] DEN_BASE = 42'sd472983273472;

  // 243.12 scaled to the result units
  localparam logic [55:0] DEW_COEF = 56'd2431200;

  // Output range of the dew point field
  localparam logic signed [17:0] DEW_MAX = 18'sd16383;
  localparam logic signed [17:0] DEW_MIN = -18'sd16384;

endpackage

`default_nettype wire

[rtl/dpm_div.sv]
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per register stage, with a side payload that travels
// alongside each request. The numerator must give a quotient below 2^QUO_W.
// ----------------------------------------------------------------------------
`default_nettype none

module dpm_div #(
  parameter int NUM_W  = 53,
  parameter int DEN_W  = 22,
  parameter int QUO_W  = 34,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QUO_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              valid_r [QUO_W];
  logic [DEN_W-1:0]  rem_r   [QUO_W];
  logic [QUO_W-1:0]  lq_r    [QUO_W];
  logic [DEN_W-1:0]  den_r   [QUO_W];
  logic [SIDE_W-1:0] side_r  [QUO_W];

  genvar s;
  for (s = 0; s < QUO_W; s++) begin : g_step
    logic              p_valid;
    logic [DEN_W-1:0]  p_rem;
    logic [QUO_W-1:0]  p_lq;
    logic [DEN_W-1:0]  p_den;
    logic [SIDE_W-1:0] p_side;
    logic [DEN_W:0]    trial;
    logic              ge;

    // Pick up the previous stage, or the request at the first one
    if (s == 0) begin : g_first
      always_comb begin
        p_valid = in_valid;
        p_rem   = DEN_W'(in_num[NUM_W-1:QUO_W]);
        p_lq    = in_num[QUO_W-1:0];
        p_den   = in_den;
        p_side  = in_side;
      end
    end else begin : g_next
      always_comb begin
        p_valid = valid_r[s-1];
        p_rem   = rem_r[s-1];
        p_lq    = lq_r[s-1];
        p_den   = den_r[s-1];
        p_side  = side_r[s-1];
      end
    end

    // Trial subtract of the next numerator bit
    assign trial = {p_rem, p_lq[QUO_W-1]};
    assign ge    = trial >= {1'b0, p_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid_r[s] <= 1'b0;
      end else if (en) begin
        valid_r[s] <= p_valid;
      end
    end

    // Advance remainder, shift in the quotient bit
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= ge ? DEN_W'(trial - {1'b0, p_den}) : DEN_W'(trial);
        lq_r[s]   <= {p_lq[QUO_W-2:0], ge};
        den_r[s]  <= p_den;
        side_r[s] <= p_side;
      end
    end
  end

  assign out_valid = valid_r[QUO_W-1];
  assign out_quo   = lq_r[QUO_W-1];
  assign out_side  = side_r[QUO_W-1];

endmodule

`default_nettype wire

[rtl/dew_point_from_temp_humidity.sv]
// ----------------------------------------------------------------------------
// Dew point from temperature and humidity
// Magnus formula dew point in fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one request per clock unless stalled and returns one result per
// request, in order. The pipeline is made up of the two bit-per-stage
// dividers (34 stages for the temperature term, 17 for the final quotient)
// plus ten stages of log lookup, interpolation and scaling. The natural log
// uses a constant table of 2^LN_TABLE_ADDR_BITS + 1 entries with linear
// interpolation. Zero humidity is treated as 0.01 % and flagged. The whole
// pipeline holds while a result waits under stall.
`default_nettype none

module dew_point_from_temp_humidity #(
  parameter int LN_TABLE_ADDR_BITS = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  dpm_pkg::sample_t sample,
  output logic             result_valid,
  input  logic             result_stall,
  output dpm_pkg::result_t result
);

  import dpm_pkg::*;

  localparam int B        = LN_TABLE_ADDR_BITS;
  localparam int RomSize  = (1 << B) + 1;
  localparam int Sh       = MANT_BITS - B;
  localparam int ProdW    = 32 + Sh;

  typedef logic [31:0] ln_rom_t [RomSize];

  // Unsigned shift-subtract quotient, used only while building the table
  function automatic logic [63:0] const_udiv(logic [63:0] a, logic [63:0] b);
    logic [63:0] q;
    logic [64:0] r;
    q = 64'd0;
    r = 65'd0;
    for (int j = 63; j >= 0; j--) begin
      r = {r[63:0], a[j]};
      if (r >= {1'b0, b}) begin
        r    = r - {1'b0, b};
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  // Build ln(1 + i/2^B) in Q28 from a truncated series in Q32
  function automatic ln_rom_t ln_rom_fill();
    ln_rom_t     rom;
    logic [63:0] n;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] e;
    n = 64'(1) << B;
    for (int i = 0; i < RomSize; i++) begin
      z   = const_udiv(64'(i) << 32, 2 * n + 64'(i));
      z2  = (z * z) >> 32;
      p   = z;
      sum = 64'd0;
      for (int d = 1; d < 400; d += 2) begin
        if (p != 64'd0) begin
          sum = sum + const_udiv(p, 64'(d));
          p   = (p * z2) >> 32;
        end
      end
      e      = (2 * sum + 64'd8) >> 4;
      rom[i] = e[31:0];
    end
    return rom;
  endfunction

  localparam ln_rom_t LnRom = ln_rom_fill();

  logic en;

  // Hold everything while the output register is stalled
  assign en           = !result_valid || !result_stall;
  assign sample_stall = !en;

  // ---------------- stage 1: capture, clamp humidity
  logic               v1;
  logic signed [14:0] t1;
  logic [13:0]        h1;
  logic               c1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= sample.temperature_centi;
      h1 <= (sample.humidity_centi == 14'd0) ? 14'd1 : sample.humidity_centi;
      c1 <= (sample.humidity_centi == 14'd0);
    end
  end

  // ---------------- stage 2: normalise humidity, set up temperature division
  logic [3:0]         e_c;
  logic [33:0]        shifted;
  logic [14:0]        tabs_c;
  logic signed [16:0] tsum;
  logic [21:0]        dent_c;

  always_comb begin
    e_c = 4'd0;
    for (int b = 1; b < 14; b++) begin
      if (h1[b]) begin
        e_c = 4'(b);
      end
    end
    shifted = {h1, 20'b0} >> e_c;
    tabs_c  = t1[14] ? 15'(-t1) : 15'(t1);
    tsum    = 17'sd24312 + 17'(t1);
    dent_c  = 22'(tsum[15:0] * 22'd100);
  end

  logic          v2;
  logic          c2;
  logic [3:0]    e2;
  logic [B-1:0]  idx2;
  logic [Sh-1:0] rem2;
  logic [14:0]   tabs2;
  logic          tneg2;
  logic [21:0]   dent2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2    <= c1;
      e2    <= e_c;
      idx2  <= shifted[MANT_BITS-1:Sh];
      rem2  <= shifted[Sh-1:0];
      tabs2 <= tabs_c;
      tneg2 <= t1[14];
      dent2 <= dent_c;
    end
  end

  // ---------------- stage 3: table lookup, scale temperature by 1762
  logic [B:0]  idx_lo;
  logic [B:0]  idx_hi;
  logic [31:0] lo_c;
  logic [31:0] hi_c;

  assign idx_lo = {1'b0, idx2};
  assign idx_hi = idx_lo + 1'b1;
  assign lo_c   = LnRom[idx_lo];
  assign hi_c   = LnRom[idx_hi];

  logic          v3;
  logic          c3;
  logic [3:0]    e3;
  logic [31:0]   lo3;
  logic [31:0]   diff3;
  logic [Sh-1:0] rem3;
  logic [24:0]   tnum3;
  logic          tneg3;
  logic [21:0]   dent3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3    <= c2;
      e3    <= e2;
      lo3   <= lo_c;
      diff3 <= hi_c - lo_c;
      rem3  <= rem2;
      tnum3 <= 25'(tabs2 * 25'd1762);
      tneg3 <= tneg2;
      dent3 <= dent2;
    end
  end

  // ---------------- stage 4: interpolate, scale the exponent, form the temperature numerator
  logic [ProdW-1:0] prod_c;
  logic [ProdW-1:0] interp_c;

  assign prod_c   = ProdW'(diff3) * ProdW'(rem3);
  assign interp_c = (prod_c + (ProdW'(1) << (Sh - 1))) >> Sh;

  logic        v4;
  logic        c4;
  logic [31:0] lo4;
  logic [31:0] interp4;
  logic [31:0] eln4;
  logic [52:0] num4;
  logic        tneg4;
  logic [21:0] dent4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4      <= c3;
      lo4     <= lo3;
      interp4 <= interp_c[31:0];
      eln4    <= 32'(36'(e3) * 36'(LnRom[RomSize-1]));
      num4    <= {tnum3, 28'b0} + 53'(dent3 >> 1);
      tneg4   <= tneg3;
      dent4   <= dent3;
    end
  end

  // ---------------- stage 5: assemble ln(h)
  logic        v5;
  logic        c5;
  logic [31:0] ln5;
  logic [52:0] num5;
  logic        tneg5;
  logic [21:0] dent5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c5    <= c4;
      ln5   <= lo4 + interp4 + eln4;
      num5  <= num4;
      tneg5 <= tneg4;
      dent5 <= dent4;
    end
  end

  // ---------------- temperature term division
  logic        dv1_valid;
  logic [33:0] dv1_quo;
  logic [33:0] dv1_side;

  dpm_div #(
    .NUM_W  (53),
    .DEN_W  (22),
    .QUO_W  (34),
    .SIDE_W (34)
  ) u_temp_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .in_num    (num5),
    .in_den    (dent5),
    .in_side   ({tneg5, c5, ln5}),
    .out_valid (dv1_valid),
    .out_quo   (dv1_quo),
    .out_side  (dv1_side)
  );

  // ---------------- stage 6: k = ln(RH) + temperature term
  logic signed [34:0] tq_c;
  logic signed [35:0] k_c;

  always_comb begin
    tq_c = dv1_side[33] ? -$signed({1'b0, dv1_quo}) : $signed({1'b0, dv1_quo});
    k_c  = $signed({4'b0, dv1_side[31:0]}) - LN10000_Q28 + 36'(tq_c);
  end

  logic               v6;
  logic               c6;
  logic signed [35:0] k6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= dv1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c6 <= dv1_side[32];
      k6 <= k_c;
    end
  end

  // ---------------- stage 7: magnitude of k and final divisor
  logic signed [41:0] den_c;

  assign den_c = DEN_BASE - 42'(k6) * 42'sd100;

  logic        v7;
  logic        c7;
  logic        kneg7;
  logic [34:0] kabs7;
  logic [40:0] den7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c7    <= c6;
      kneg7 <= k6[35];
      kabs7 <= k6[35] ? 35'(-k6) : 35'(k6);
      den7  <= den_c[40:0];
    end
  end

  // ---------------- stage 8: scale k
  logic        v8;
  logic        c8;
  logic        kneg8;
  logic [55:0] prod8;
  logic [40:0] den8;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c8    <= c7;
      kneg8 <= kneg7;
      prod8 <= 56'(kabs7) * DEW_COEF;
      den8  <= den7;
    end
  end

  // ---------------- stage 9: add half divisor for rounding
  logic        v9;
  logic        c9;
  logic        kneg9;
  logic [55:0] num9;
  logic [40:0] den9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c9    <= c8;
      kneg9 <= kneg8;
      num9  <= prod8 + 56'(den8 >> 1);
      den9  <= den8;
    end
  end

  // ---------------- dew point division
  logic        dv2_valid;
  logic [16:0] dv2_quo;
  logic [1:0]  dv2_side;

  dpm_div #(
    .NUM_W  (56),
    .DEN_W  (41),
    .QUO_W  (17),
    .SIDE_W (2)
  ) u_dew_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v9),
    .in_num    (num9),
    .in_den    (den9),
    .in_side   ({kneg9, c9}),
    .out_valid (dv2_valid),
    .out_quo   (dv2_quo),
    .out_side  (dv2_side)
  );

  // ---------------- output register: sign and saturate
  logic signed [17:0] dew_c;
  logic signed [17:0] dew_sat;

  always_comb begin
    dew_c = dv2_side[1] ? -$signed({1'b0, dv2_quo}) : $signed({1'b0, dv2_quo});
    if (dew_c > DEW_MAX) begin
      dew_sat = DEW_MAX;
    end else if (dew_c < DEW_MIN) begin
      dew_sat = DEW_MIN;
    end else begin
      dew_sat = dew_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= dv2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.dew_point_centi  <= dew_sat[14:0];
      result.humidity_clamped <= dv2_side[0];
    end
  end

endmodule

`default_nettype wire

[sim/dew_point_checker.sv]
// ----------------------------------------------------------------------------
// Dew point checker
// Watches both channels of the dew point block and predicts each result
// from the accepted request. Compares results in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module dew_point_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             sample_valid,
  input  logic             sample_stall,
  input  dpm_pkg::sample_t sample,
  input  logic             result_valid,
  input  logic             result_stall,
  input  dpm_pkg::result_t result,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_BITS = 8;
  localparam int TBL_SIZE = (1 << TBL_BITS) + 1;
  localparam longint LN_10K = 64'sd2472381918;

  longint unsigned ln_table [TBL_SIZE];
  dpm_pkg::result_t dew_queue [$];

  // Build the ln(1 + i/2^B) table by the odd-power series in Q32
  initial begin
    longint unsigned z, z2, p, acc, d, n;
    n = 1 << TBL_BITS;
    for (int i = 0; i < TBL_SIZE; i++) begin
      z = (longint'(i) << 32) / (2 * n + i);
      z2 = (z * z) >> 32;
      p = z;
      acc = 0;
      d = 1;
      while (p != 0 && d < 400) begin
        acc += p / d;
        p = (p * z2) >> 32;
        d += 2;
      end
      ln_table[i] = ((2 * acc + 8) >> 4) & 64'hFFFF_FFFF;
    end
  end

  function automatic longint round_quot(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  // Natural log of h in Q28 by table lookup and linear interpolation
  function automatic longint ln_fixed(int unsigned h);
    int unsigned e;
    longint unsigned frac, idx, rem, lo, hi;
    e = 0;
    while (e < 13 && (h >> (e + 1)) != 0) e++;
    frac = (longint'(h) << (20 - e)) - (64'd1 << 20);
    idx = (frac >> (20 - TBL_BITS)) & ((1 << TBL_BITS) - 1);
    rem = frac & ((1 << (20 - TBL_BITS)) - 1);
    lo = ln_table[idx];
    hi = ln_table[idx + 1];
    return longint'(e) * longint'(ln_table[TBL_SIZE - 1]) +
           longint'(lo + (((hi - lo) * rem + (1 << (19 - TBL_BITS))) >> (20 - TBL_BITS)));
  endfunction

  function automatic dpm_pkg::result_t dew_point(dpm_pkg::sample_t s);
    dpm_pkg::result_t r;
    longint t, k, den, dew;
    int unsigned h;
    t = s.temperature_centi;
    h = s.humidity_centi;
    r.humidity_clamped = (h == 0);
    if (h == 0) h = 1;
    k = ln_fixed(h) - LN_10K;
    k += round_quot(1762 * t * (64'sd1 <<< 28), 100 * (24312 + t));
    den = 1762 * (64'sd1 <<< 28) - 100 * k;
    if (den <= 0) begin
      dew = 16383;
    end else begin
      dew = round_quot(2431200 * k, den);
      if (dew > 16383) dew = 16383;
      if (dew < -16384) dew = -16384;
    end
    r.dew_point_centi = dew[14:0];
    return r;
  endfunction

  // Predict on each accepted request, compare on each accepted result
  always @(posedge clk) begin
    dpm_pkg::result_t want;
    int bad;
    bad = 0;
    if (rst) begin
      errors <= 0;
    end else begin
      if (sample_valid && !sample_stall) dew_queue.push_back(dew_point(sample));
      if (result_valid && !result_stall) begin
        if (dew_queue.size() == 0) begin
          $error("unexpected result %0d/%0d", result.dew_point_centi,
                 result.humidity_clamped);
          bad++;
        end else begin
          want = dew_queue.pop_front();
          if (want.dew_point_centi !== result.dew_point_centi) begin
            $error("dew_point_centi: expected %0d, got %0d",
                   want.dew_point_centi, result.dew_point_centi);
            bad++;
          end
          if (want.humidity_clamped !== result.humidity_clamped) begin
            $error("humidity_clamped: expected %0b, got %0b",
                   want.humidity_clamped, result.humidity_clamped);
            bad++;
          end
        end
      end
      errors <= errors + bad;
    end
    pending <= dew_queue.size();
  end
endmodule

`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// Dew point testbench
// Drives directed and random requests through the dew point block under
// varying idle and stall patterns; the checker judges every result.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  dpm_pkg::sample_t sample = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  dpm_pkg::result_t result;
  int errors, pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  dew_point_from_temp_humidity DUT (
    .clk, .rst, .sample_valid, .sample_stall, .sample,
    .result_valid, .result_stall, .result
  );

  dew_point_checker u_checker (
    .clk, .rst, .sample_valid, .sample_stall, .sample,
    .result_valid, .result_stall, .result, .errors, .pending
  );

  // Stall the result side at random
  always @(negedge clk) begin
    result_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  // Watchdog: count cycles with no handshake on either side
  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (!rst) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // Send one request, idling first at random, and hold it until accepted
  task automatic send_request(logic signed [14:0] temp, logic [13:0] hum);
    while ($urandom_range(99) < idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= '{temperature_centi: temp, humidity_centi: hum};
    do @(posedge clk); while (sample_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8)
        send_request($signed(15'($urandom_range(16500)) - 15'sd4000),
                     14'($urandom_range(10000)));
      else
        send_request(15'($urandom), 14'($urandom));
    end
  endtask

  initial begin
    logic signed [14:0] temps [6] = '{-15'sd16384, 15'sd16383, -15'sd4000,
                                      15'sd12500, 15'sd0, -15'sd1};
    logic [13:0] hums [4] = '{14'd0, 14'd1, 14'd10000, 14'd16383};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: field extremes, zero humidity, humidity above full scale
    foreach (temps[i]) foreach (hums[j]) send_request(temps[i], hums[j]);

    idle_pct = 38;
    stall_pct = 67;
    random_phase(630);
    // Hold off until the pipeline has emptied
    drain();
    idle_pct = 67;
    stall_pct = 38;
    random_phase(630);
    idle_pct = 0;
    stall_pct = 0;
    random_phase(640);

    drain();
    if (errors == 0 && pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

`default_nettype wire
